// File: rtl/h264f_pkg.sv
// Shared types and constants for the H.264 RTP FU-A fragmenter.
// No dependencies; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package h264f_pkg;

  localparam int unsigned MTU_W   = 11;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [MTU_W-1:0] MTU_RESET = 11'd1436;
  localparam logic [MTU_W-1:0] MTU_FLOOR = 11'd1100;

  localparam logic [7:0] FU_A_TYPE = 8'd28;
  localparam logic [7:0] NRI_MASK  = 8'hE0;
  localparam logic [7:0] START_BIT = 8'h80;
  localparam logic [7:0] HDR_MASK  = 8'h9F;
  localparam logic [7:0] STRT_CLR  = 8'h7F;
  localparam logic [7:0] END_BIT   = 8'h40;

  // register index of mtu_bytes
  localparam logic REG_MTU = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_FRAG
  } state_e;

  typedef struct packed {
    logic load;
    logic emit_single;
    logic emit_first;
    logic emit_next;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic single;
    logic tail;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/h264f_if.sv
// Valid/ready channel interfaces: NAL descriptors in, packet descriptors out.
// Depends on h264f_pkg for field widths.
`default_nettype none

interface h264f_nal_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     nal_header;
  logic [h264f_pkg::LEN_W-1:0]    nal_length;
  logic [h264f_pkg::TIME_W-1:0]   timestamp;
  logic                           last_nal;

  modport source (output valid, nal_header, nal_length, timestamp, last_nal,
                  input ready);
  modport sink   (input valid, nal_header, nal_length, timestamp, last_nal,
                  output ready);
endinterface

interface h264f_pkt_if;
  logic                           valid;
  logic                           ready;
  logic [7:0]                     fu_indicator;
  logic [7:0]                     fu_header;
  logic                           has_prefix;
  logic [h264f_pkg::LEN_W-1:0]    byte_offset;
  logic [h264f_pkg::LEN_W-1:0]    payload_bytes;
  logic [h264f_pkg::LEN_W-1:0]    packet_size;
  logic [h264f_pkg::TIME_W-1:0]   packet_time;
  logic                           marker;
  logic                           run_end;

  modport source (output valid, fu_indicator, fu_header, has_prefix, byte_offset,
                  payload_bytes, packet_size, packet_time, marker, run_end,
                  input ready);
  modport sink   (input valid, fu_indicator, fu_header, has_prefix, byte_offset,
                  payload_bytes, packet_size, packet_time, marker, run_end,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/h264_rtp_fua_fragmenter.sv
// H.264 RTP FU-A fragmenter top level: APB register, sequencer, datapath.
// Flow: a NAL word is loaded into the NAL context registers, then the sequencer
//   writes its P packets into the single packet output register, one per cycle
//   while the sink keeps ready high; the next NAL is taken after the last packet.
// Reset: rst_ni (async, low) idles the sequencer, empties the output register
//   and sets mtu_bytes to 1436. Depends on h264f_pkg, h264f_if, ctrl, dp.
`default_nettype none

module h264_rtp_fua_fragmenter (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // APB-style config port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [h264f_pkg::PADDR_W-1:0]     paddr,
  input  wire  [h264f_pkg::PDATA_W-1:0]     pwdata,
  output logic [h264f_pkg::PDATA_W-1:0]     prdata,
  output logic                              pready,
  // NAL descriptor words in, packet descriptor words out
  h264f_nal_if.sink                         nal_i,
  h264f_pkt_if.source                       pkt_o
);

  localparam int unsigned RD_PAD = h264f_pkg::PDATA_W - h264f_pkg::MTU_W;

  // mtu_bytes register; stored raw, the floor is applied when a NAL loads
  logic [h264f_pkg::MTU_W-1:0] mtu_q;
  logic                        reg_idx;
  logic                        cfg_wr;

  h264f_pkg::ctrl_cmd_t  cmd;
  h264f_pkg::dp_status_t status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];            // 4-byte stride, low bits ignored
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == h264f_pkg::REG_MTU);
  assign prdata  = (reg_idx == h264f_pkg::REG_MTU) ? {{RD_PAD{1'b0}}, mtu_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q <= h264f_pkg::MTU_RESET;
    end else if (cfg_wr) begin
      mtu_q <= pwdata[h264f_pkg::MTU_W-1:0];
    end
  end

  // sequencer: idle -> start (single or first fragment) -> fragments
  h264f_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (nal_i.valid),
    .in_ready_o (nal_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  h264f_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mtu_cfg_i    (mtu_q),
    .nal_header_i (nal_i.nal_header),
    .nal_length_i (nal_i.nal_length),
    .timestamp_i  (nal_i.timestamp),
    .last_nal_i   (nal_i.last_nal),
    .cmd_i        (cmd),
    .status_o     (status),
    .pkt          (pkt_o)
  );

  // a NAL is held until its last packet has been issued
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nal_i.valid && nal_i.ready) |=> !nal_i.ready)
    else $error("input accepted again right after a NAL word");

  // marker only ever rides on the last packet of a NAL
  a_marker_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pkt_o.valid && pkt_o.marker) |-> pkt_o.run_end)
    else $error("marker set on a packet that does not end its NAL");

  // packet size accounts for the FU prefix
  a_size_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_o.valid |-> (pkt_o.packet_size ==
      (pkt_o.has_prefix ? pkt_o.payload_bytes + 16'd2 : pkt_o.payload_bytes)))
    else $error("packet_size inconsistent with payload and prefix");

  // no more than one command per cycle
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.emit_single, cmd.emit_first, cmd.emit_next}))
    else $error("sequencer issued more than one command");

endmodule

`default_nettype wire

// File: rtl/h264f_ctrl.sv
// Sequencer for the fragmenter: accepts a NAL word and steps the datapath
// through its packets. Depends on h264f_pkg.
`default_nettype none

module h264f_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  h264f_pkg::dp_status_t  status_i,
  output h264f_pkg::ctrl_cmd_t   cmd_o
);

  h264f_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= h264f_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      h264f_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = h264f_pkg::ST_START;
        end
      end
      h264f_pkg::ST_START: begin
        if (status_i.out_free) begin
          if (status_i.single) begin
            cmd_o.emit_single = 1'b1;
            state_d           = h264f_pkg::ST_IDLE;
          end else begin
            cmd_o.emit_first = 1'b1;
            state_d          = h264f_pkg::ST_FRAG;
          end
        end
      end
      h264f_pkg::ST_FRAG: begin
        if (status_i.out_free) begin
          cmd_o.emit_next = 1'b1;
          if (status_i.tail) begin
            state_d = h264f_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = h264f_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/h264f_dp.sv
// Fragmenter datapath: NAL context, offset/remaining counters and the
// packet output register. Depends on h264f_pkg and h264f_if.
`default_nettype none

module h264f_dp (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire  [h264f_pkg::MTU_W-1:0]        mtu_cfg_i,
  input  wire  [7:0]                         nal_header_i,
  input  wire  [h264f_pkg::LEN_W-1:0]        nal_length_i,
  input  wire  [h264f_pkg::TIME_W-1:0]       timestamp_i,
  input  wire                                last_nal_i,
  input  h264f_pkg::ctrl_cmd_t               cmd_i,
  output h264f_pkg::dp_status_t              status_o,
  h264f_pkt_if.source                        pkt
);

  localparam int unsigned PADW = h264f_pkg::LEN_W - h264f_pkg::MTU_W;

  // NAL context
  logic [7:0]                   hdr_q;
  logic [h264f_pkg::TIME_W-1:0] time_q;
  logic                         last_q;
  logic [h264f_pkg::MTU_W-1:0]  mtu_q;
  logic [h264f_pkg::MTU_W-1:0]  chunk_q;
  logic [h264f_pkg::LEN_W-1:0]  off_q;
  logic [h264f_pkg::LEN_W-1:0]  left_q;

  // packet register
  logic                         vld_q;
  logic [7:0]                   ind_q;
  logic [7:0]                   fuh_q;
  logic                         pre_q;
  logic [h264f_pkg::LEN_W-1:0]  boff_q;
  logic [h264f_pkg::LEN_W-1:0]  pay_q;
  logic [h264f_pkg::LEN_W-1:0]  size_q;
  logic [h264f_pkg::TIME_W-1:0] ptime_q;
  logic                         mark_q;
  logic                         rend_q;

  logic [h264f_pkg::MTU_W-1:0]  mtu_eff;
  logic [h264f_pkg::LEN_W-1:0]  chunk_w;
  logic [h264f_pkg::LEN_W-1:0]  mtu_w;
  logic [7:0]                   start_hdr;
  logic [7:0]                   mid_hdr;
  logic                         emit;

  assign mtu_eff   = (mtu_cfg_i < h264f_pkg::MTU_FLOOR) ? h264f_pkg::MTU_FLOOR : mtu_cfg_i;
  assign chunk_w   = {{PADW{1'b0}}, chunk_q};
  assign mtu_w     = {{PADW{1'b0}}, mtu_q};
  assign start_hdr = (hdr_q | h264f_pkg::START_BIT) & h264f_pkg::HDR_MASK;
  assign mid_hdr   = start_hdr & h264f_pkg::STRT_CLR;
  assign emit      = cmd_i.emit_single | cmd_i.emit_first | cmd_i.emit_next;

  assign status_o.out_free = !vld_q || pkt.ready;
  assign status_o.single   = (left_q <= mtu_w);
  assign status_o.tail     = (left_q <= chunk_w);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hdr_q   <= nal_header_i;
      time_q  <= timestamp_i;
      last_q  <= last_nal_i;
      mtu_q   <= mtu_eff;
      chunk_q <= mtu_eff - h264f_pkg::MTU_W'(2);
      left_q  <= nal_length_i;
    end else if (cmd_i.emit_first) begin
      off_q  <= 16'd1 + chunk_w;
      left_q <= left_q - 16'd1 - chunk_w;
    end else if (cmd_i.emit_next) begin
      off_q  <= off_q + chunk_w;
      left_q <= left_q - chunk_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ptime_q <= time_q;
    end
    if (cmd_i.emit_single) begin
      ind_q  <= 8'd0;
      fuh_q  <= 8'd0;
      pre_q  <= 1'b0;
      boff_q <= '0;
      pay_q  <= left_q;
      size_q <= left_q;
      mark_q <= last_q;
      rend_q <= 1'b1;
    end else if (cmd_i.emit_first || cmd_i.emit_next) begin
      ind_q <= (hdr_q & h264f_pkg::NRI_MASK) | h264f_pkg::FU_A_TYPE;
      pre_q <= 1'b1;
      if (cmd_i.emit_first) begin
        fuh_q  <= start_hdr;
        boff_q <= 16'd1;
        pay_q  <= chunk_w;
        size_q <= mtu_w;
        mark_q <= 1'b0;
        rend_q <= 1'b0;
      end else if (status_o.tail) begin
        // end fragment carries whatever is left
        fuh_q  <= mid_hdr | h264f_pkg::END_BIT;
        boff_q <= off_q;
        pay_q  <= left_q;
        size_q <= left_q + 16'd2;
        mark_q <= last_q;
        rend_q <= 1'b1;
      end else begin
        fuh_q  <= mid_hdr;
        boff_q <= off_q;
        pay_q  <= chunk_w;
        size_q <= mtu_w;
        mark_q <= 1'b0;
        rend_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (emit) begin
      vld_q <= 1'b1;
    end else if (pkt.ready) begin
      vld_q <= 1'b0;
    end
  end

  assign pkt.valid         = vld_q;
  assign pkt.fu_indicator  = ind_q;
  assign pkt.fu_header     = fuh_q;
  assign pkt.has_prefix    = pre_q;
  assign pkt.byte_offset   = boff_q;
  assign pkt.payload_bytes = pay_q;
  assign pkt.packet_size   = size_q;
  assign pkt.packet_time   = ptime_q;
  assign pkt.marker        = mark_q;
  assign pkt.run_end       = rend_q;

endmodule

`default_nettype wire
